### src/jbt_pkg.sv
`default_nettype none

package jbt_pkg;

  // Token kinds reported on the result channel
  localparam logic [3:0] K_END    = 4'd0;
  localparam logic [3:0] K_LBRACE = 4'd1;
  localparam logic [3:0] K_RBRACE = 4'd2;
  localparam logic [3:0] K_LBRACK = 4'd3;
  localparam logic [3:0] K_RBRACK = 4'd4;
  localparam logic [3:0] K_COLON  = 4'd5;
  localparam logic [3:0] K_COMMA  = 4'd6;
  localparam logic [3:0] K_NULL   = 4'd7;
  localparam logic [3:0] K_TRUE   = 4'd8;
  localparam logic [3:0] K_FALSE  = 4'd9;
  localparam logic [3:0] K_NUMBER = 4'd10;
  localparam logic [3:0] K_STRING = 4'd11;
  localparam logic [3:0] K_ERROR  = 4'd12;

  // Most results one input byte can cause
  localparam int MAX_RES = 3;

  // One result item
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data;
    logic       valid;
    logic       done;
  } result_t;

  // All results caused by one input byte, slot 0 first
  typedef struct packed {
    logic [1:0]               cnt;
    result_t [MAX_RES-1:0]    res;
  } bundle_t;

  // Queue status seen by the top level and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

### src/json_byte_tokenizer_unit.sv
// JSON byte tokenizer.
// Input stream: one text byte per transaction on in_tdata[7:0]; byte 0 ends
// the text. Output stream: token events, up to three per input byte, with
// out_tlast marking the final event caused by a byte. Whitespace, opening
// quotes, backslashes, early hex digits and early keyword letters give none.
// The front scan stage updates the tokenizer state in the cycle a byte is
// accepted and queues the byte's events as one bundle; the back stage plays
// bundles out one event per cycle while out_tready is high, from a
// registered output. The first event of a byte is written into the queue
// and then loaded into the back stage's bundle register before it leaves.
// Throughput: one byte per cycle while each byte gives at most one event
// and out_tready is high; a byte with more events holds the output until
// they have all left, and the queue of QUEUE_DEPTH bundles absorbs this.
// When the receiver stalls, events wait at the output and the queue fills;
// in_tready drops only when the queue is full.
// Reset (rst_n low, synchronous) empties the queue, returns the scanner to
// idle between tokens and clears the sticky error state.
`default_nettype none

module json_byte_tokenizer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [8] token_done, rest zero
  output logic [4:0]       out_tuser,  // [3:0] token_kind, [4] byte_valid
  output logic             out_tlast   // last_result
);
  import jbt_pkg::*;

  bundle_t   push_bundle;
  bundle_t   pop_bundle;
  logic      push;
  logic      pop;
  logic      in_fire;
  q_status_t q_status;

  assign in_tready = !q_status.full;
  assign in_fire   = in_tvalid && in_tready;

  jbt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_byte     (in_tdata),
    .push_bundle (push_bundle),
    .push        (push)
  );

  jbt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_bundle),
    .pop       (pop),
    .pop_data  (pop_bundle),
    .status    (q_status)
  );

  jbt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_data   (pop_bundle),
    .status     (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### src/jbt_front.sv
`default_nettype none

module jbt_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic [7:0]      in_byte,
  output jbt_pkg::bundle_t     push_bundle,
  output logic                 push
);
  import jbt_pkg::*;

  typedef enum logic [12:0] {
    M_IDLE    = 13'b0000000000001,
    M_KEYWORD = 13'b0000000000010,
    M_NSIGN   = 13'b0000000000100,
    M_NZERO   = 13'b0000000001000,
    M_NINT    = 13'b0000000010000,
    M_NDOT    = 13'b0000000100000,
    M_NFRAC   = 13'b0000001000000,
    M_NE      = 13'b0000010000000,
    M_NESIGN  = 13'b0000100000000,
    M_NEXP    = 13'b0001000000000,
    M_STR     = 13'b0010000000000,
    M_ESC     = 13'b0100000000000,
    M_HEX     = 13'b1000000000000
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] KW_NULL  = 2'd0;
  localparam logic [1:0] KW_TRUE  = 2'd1;
  localparam logic [1:0] KW_FALSE = 2'd2;

  // Letter expected at a keyword position
  function automatic logic [7:0] kw_char(input logic [1:0] w, input logic [2:0] p);
    logic [7:0] c;
    c = 8'h00;
    case ({w, p})
      {KW_NULL, 3'd0}:  c = 8'h6e;
      {KW_NULL, 3'd1}:  c = 8'h75;
      {KW_NULL, 3'd2}:  c = 8'h6c;
      {KW_NULL, 3'd3}:  c = 8'h6c;
      {KW_TRUE, 3'd0}:  c = 8'h74;
      {KW_TRUE, 3'd1}:  c = 8'h72;
      {KW_TRUE, 3'd2}:  c = 8'h75;
      {KW_TRUE, 3'd3}:  c = 8'h65;
      {KW_FALSE, 3'd0}: c = 8'h66;
      {KW_FALSE, 3'd1}: c = 8'h61;
      {KW_FALSE, 3'd2}: c = 8'h6c;
      {KW_FALSE, 3'd3}: c = 8'h73;
      {KW_FALSE, 3'd4}: c = 8'h65;
      default:          c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] w);
    return (w == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // Hex digit value; bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    if (is_digit(b)) begin
      v = {1'b0, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      v = {1'b0, b[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  function automatic result_t mk(input logic [3:0] k, input logic [7:0] d,
                                 input logic v, input logic dn);
    result_t r;
    r.kind  = k;
    r.data  = v ? d : 8'h00;
    r.valid = v;
    r.done  = dn;
    return r;
  endfunction

  // State registers
  mode_t       mode_r, mode_nxt;
  logic [1:0]  kw_which_r, kw_which_nxt;
  logic [2:0]  kw_pos_r, kw_pos_nxt;
  logic [15:0] hex_acc_r, hex_acc_nxt;
  logic [2:0]  hex_cnt_r, hex_cnt_nxt;
  logic        err_r, err_nxt;

  // Start-of-token decode of the incoming byte
  logic        st_has;
  result_t     st_res;
  mode_t       st_mode;
  logic        st_kw;
  logic [1:0]  st_which;
  logic        st_err;

  always_comb begin
    st_has   = 1'b0;
    st_res   = mk(K_END, 8'h00, 1'b0, 1'b1);
    st_mode  = M_IDLE;
    st_kw    = 1'b0;
    st_which = KW_NULL;
    st_err   = 1'b0;
    case (in_byte)
      8'h00: begin st_has = 1'b1; st_res = mk(K_END, 8'h00, 1'b0, 1'b1); end
      8'h20, 8'h09, 8'h0a, 8'h0d: st_has = 1'b0;
      8'h7b: begin st_has = 1'b1; st_res = mk(K_LBRACE, 8'h00, 1'b0, 1'b1); end
      8'h7d: begin st_has = 1'b1; st_res = mk(K_RBRACE, 8'h00, 1'b0, 1'b1); end
      8'h5b: begin st_has = 1'b1; st_res = mk(K_LBRACK, 8'h00, 1'b0, 1'b1); end
      8'h5d: begin st_has = 1'b1; st_res = mk(K_RBRACK, 8'h00, 1'b0, 1'b1); end
      8'h3a: begin st_has = 1'b1; st_res = mk(K_COLON, 8'h00, 1'b0, 1'b1); end
      8'h2c: begin st_has = 1'b1; st_res = mk(K_COMMA, 8'h00, 1'b0, 1'b1); end
      8'h6e: begin st_kw = 1'b1; st_which = KW_NULL;  st_mode = M_KEYWORD; end
      8'h74: begin st_kw = 1'b1; st_which = KW_TRUE;  st_mode = M_KEYWORD; end
      8'h66: begin st_kw = 1'b1; st_which = KW_FALSE; st_mode = M_KEYWORD; end
      CH_MINUS: begin
        st_has = 1'b1; st_res = mk(K_NUMBER, in_byte, 1'b1, 1'b0); st_mode = M_NSIGN;
      end
      CH_ZERO: begin
        st_has = 1'b1; st_res = mk(K_NUMBER, in_byte, 1'b1, 1'b0); st_mode = M_NZERO;
      end
      CH_QUOTE: st_mode = M_STR;
      default: begin
        if (is_digit(in_byte)) begin
          st_has = 1'b1; st_res = mk(K_NUMBER, in_byte, 1'b1, 1'b0); st_mode = M_NINT;
        end else begin
          st_has = 1'b1; st_res = mk(K_ERROR, 8'h00, 1'b0, 1'b1); st_err = 1'b1;
        end
      end
    endcase
  end

  // Main scan step
  bundle_t     bnd;
  logic        do_start;
  logic [1:0]  kw_w;
  logic [2:0]  kw_p;
  logic [2:0]  kw_p1;
  logic [4:0]  hv;
  logic [15:0] acc;
  logic [2:0]  hcnt1;
  logic [7:0]  esc_v;
  logic        esc_ok;

  always_comb begin
    mode_nxt     = mode_r;
    kw_which_nxt = kw_which_r;
    kw_pos_nxt   = kw_pos_r;
    hex_acc_nxt  = hex_acc_r;
    hex_cnt_nxt  = hex_cnt_r;
    err_nxt      = err_r;
    bnd          = '0;
    do_start     = 1'b0;
    kw_w         = (kw_which_r == 2'd3) ? KW_NULL : kw_which_r;
    kw_p         = (kw_pos_r < kw_len(kw_w)) ? kw_pos_r : 3'd0;
    kw_p1        = kw_p + 3'd1;
    hv           = hex_value(in_byte);
    acc          = {hex_acc_r[11:0], hv[3:0]};
    hcnt1        = hex_cnt_r + 3'd1;
    esc_v        = 8'h00;
    esc_ok       = 1'b1;
    case (in_byte)
      CH_QUOTE: esc_v = CH_QUOTE;
      CH_BSL:   esc_v = CH_BSL;
      CH_SLASH: esc_v = CH_SLASH;
      8'h62:    esc_v = 8'h08;
      8'h66:    esc_v = 8'h0c;
      8'h6e:    esc_v = 8'h0a;
      8'h72:    esc_v = 8'h0d;
      8'h74:    esc_v = 8'h09;
      default:  esc_ok = 1'b0;
    endcase

    if (err_r) begin
      bnd.res[0] = mk(K_ERROR, 8'h00, 1'b0, 1'b1);
      bnd.cnt    = 2'd1;
    end else begin
      case (mode_r)
        M_KEYWORD: begin
          if (in_byte != kw_char(kw_w, kw_p)) begin
            err_nxt = 1'b1;
          end else begin
            kw_pos_nxt = kw_p1;
            if (kw_p1 >= kw_len(kw_w)) begin
              bnd.res[0] = mk(K_NULL + {2'b00, kw_w}, 8'h00, 1'b0, 1'b1);
              bnd.cnt    = 2'd1;
              mode_nxt   = M_IDLE;
            end
          end
        end
        M_NSIGN: begin
          if (is_digit(in_byte)) begin
            bnd.res[0] = mk(K_NUMBER, in_byte, 1'b1, 1'b0);
            bnd.cnt    = 2'd1;
            mode_nxt   = (in_byte == CH_ZERO) ? M_NZERO : M_NINT;
          end else begin
            err_nxt = 1'b1;
          end
        end
        M_NZERO, M_NINT: begin
          if (is_digit(in_byte)) begin
            if (mode_r == M_NZERO) begin
              err_nxt = 1'b1;
            end else begin
              bnd.res[0] = mk(K_NUMBER, in_byte, 1'b1, 1'b0);
              bnd.cnt    = 2'd1;
            end
          end else if (in_byte == CH_DOT) begin
            bnd.res[0] = mk(K_NUMBER, in_byte, 1'b1, 1'b0);
            bnd.cnt    = 2'd1;
            mode_nxt   = M_NDOT;
          end else if (in_byte == CH_LO_E || in_byte == CH_UP_E) begin
            bnd.res[0] = mk(K_NUMBER, in_byte, 1'b1, 1'b0);
            bnd.cnt    = 2'd1;
            mode_nxt   = M_NE;
          end else begin
            do_start = 1'b1;
          end
        end
        M_NDOT: begin
          if (is_digit(in_byte)) begin
            bnd.res[0] = mk(K_NUMBER, in_byte, 1'b1, 1'b0);
            bnd.cnt    = 2'd1;
            mode_nxt   = M_NFRAC;
          end else begin
            err_nxt = 1'b1;
          end
        end
        M_NFRAC: begin
          if (is_digit(in_byte)) begin
            bnd.res[0] = mk(K_NUMBER, in_byte, 1'b1, 1'b0);
            bnd.cnt    = 2'd1;
          end else if (in_byte == CH_LO_E || in_byte == CH_UP_E) begin
            bnd.res[0] = mk(K_NUMBER, in_byte, 1'b1, 1'b0);
            bnd.cnt    = 2'd1;
            mode_nxt   = M_NE;
          end else begin
            do_start = 1'b1;
          end
        end
        M_NE: begin
          if (in_byte == CH_PLUS || in_byte == CH_MINUS) begin
            bnd.res[0] = mk(K_NUMBER, in_byte, 1'b1, 1'b0);
            bnd.cnt    = 2'd1;
            mode_nxt   = M_NESIGN;
          end else if (is_digit(in_byte)) begin
            bnd.res[0] = mk(K_NUMBER, in_byte, 1'b1, 1'b0);
            bnd.cnt    = 2'd1;
            mode_nxt   = M_NEXP;
          end else begin
            err_nxt = 1'b1;
          end
        end
        M_NESIGN: begin
          if (is_digit(in_byte)) begin
            bnd.res[0] = mk(K_NUMBER, in_byte, 1'b1, 1'b0);
            bnd.cnt    = 2'd1;
            mode_nxt   = M_NEXP;
          end else begin
            err_nxt = 1'b1;
          end
        end
        M_NEXP: begin
          if (is_digit(in_byte)) begin
            bnd.res[0] = mk(K_NUMBER, in_byte, 1'b1, 1'b0);
            bnd.cnt    = 2'd1;
          end else begin
            do_start = 1'b1;
          end
        end
        M_STR: begin
          if (in_byte < CH_SPACE) begin
            err_nxt = 1'b1;
          end else if (in_byte == CH_QUOTE) begin
            bnd.res[0] = mk(K_STRING, 8'h00, 1'b0, 1'b1);
            bnd.cnt    = 2'd1;
            mode_nxt   = M_IDLE;
          end else if (in_byte == CH_BSL) begin
            mode_nxt = M_ESC;
          end else begin
            bnd.res[0] = mk(K_STRING, in_byte, 1'b1, 1'b0);
            bnd.cnt    = 2'd1;
          end
        end
        M_ESC: begin
          mode_nxt = M_STR;
          if (in_byte == 8'h75) begin
            hex_acc_nxt = 16'h0000;
            hex_cnt_nxt = 3'd0;
            mode_nxt    = M_HEX;
          end else if (esc_ok) begin
            bnd.res[0] = mk(K_STRING, esc_v, 1'b1, 1'b0);
            bnd.cnt    = 2'd1;
          end else begin
            err_nxt = 1'b1;
          end
        end
        M_HEX: begin
          if (hv[4]) begin
            err_nxt = 1'b1;
          end else begin
            hex_acc_nxt = acc;
            hex_cnt_nxt = hcnt1;
            if (hcnt1 >= 3'd4) begin
              hex_cnt_nxt = 3'd0;
              mode_nxt    = M_STR;
              // Encode the code point as UTF-8; code point zero adds nothing
              if (acc <= 16'h007f) begin
                if (acc != 16'h0000) begin
                  bnd.res[0] = mk(K_STRING, acc[7:0], 1'b1, 1'b0);
                  bnd.cnt    = 2'd1;
                end
              end else if (acc <= 16'h07ff) begin
                bnd.res[0] = mk(K_STRING, {3'b110, acc[10:6]}, 1'b1, 1'b0);
                bnd.res[1] = mk(K_STRING, {2'b10, acc[5:0]}, 1'b1, 1'b0);
                bnd.cnt    = 2'd2;
              end else begin
                bnd.res[0] = mk(K_STRING, {4'b1110, acc[15:12]}, 1'b1, 1'b0);
                bnd.res[1] = mk(K_STRING, {2'b10, acc[11:6]}, 1'b1, 1'b0);
                bnd.res[2] = mk(K_STRING, {2'b10, acc[5:0]}, 1'b1, 1'b0);
                bnd.cnt    = 2'd3;
              end
            end
          end
        end
        default: do_start = 1'b1;
      endcase

      // Close a pending number, then treat the byte as a token start
      if (do_start) begin
        if (mode_r != M_IDLE) begin
          bnd.res[0] = mk(K_NUMBER, 8'h00, 1'b0, 1'b1);
          bnd.cnt    = 2'd1;
        end
        mode_nxt = st_mode;
        if (st_has) begin
          bnd.res[bnd.cnt] = st_res;
          bnd.cnt          = bnd.cnt + 2'd1;
        end
        if (st_kw) begin
          kw_which_nxt = st_which;
          kw_pos_nxt   = 3'd1;
        end
        if (st_err) begin
          err_nxt = 1'b1;
        end
      end else if (err_nxt) begin
        // Fail from inside a token
        bnd.res[bnd.cnt] = mk(K_ERROR, 8'h00, 1'b0, 1'b1);
        bnd.cnt          = bnd.cnt + 2'd1;
        mode_nxt         = M_IDLE;
      end
    end
  end

  // Advance state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      kw_which_r <= 2'd0;
      kw_pos_r   <= 3'd0;
      hex_acc_r  <= 16'h0000;
      hex_cnt_r  <= 3'd0;
      err_r      <= 1'b0;
    end else if (in_fire) begin
      mode_r     <= mode_nxt;
      kw_which_r <= kw_which_nxt;
      kw_pos_r   <= kw_pos_nxt;
      hex_acc_r  <= hex_acc_nxt;
      hex_cnt_r  <= hex_cnt_nxt;
      err_r      <= err_nxt;
    end
  end

  assign push_bundle = bnd;
  assign push        = in_fire && (bnd.cnt != 2'd0);

  // Error stays until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r) else $error("error flag cleared without reset");

  // Once in error every accepted byte yields exactly one error result
  a_err_one: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && err_r) |-> (push && bnd.cnt == 2'd1 && bnd.res[0].kind == K_ERROR))
    else $error("error state gave a wrong result bundle");

endmodule

`default_nettype wire

### src/jbt_queue.sv
`default_nettype none

module jbt_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire jbt_pkg::bundle_t  push_data,
  input  wire logic              pop,
  output jbt_pkg::bundle_t       pop_data,
  output jbt_pkg::q_status_t     status
);
  import jbt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         store_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold bundle payloads
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = store_r[rd_ptr_r];
  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && status.full)) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && status.empty)) else $error("pop from empty queue");

endmodule

`default_nettype wire

### src/jbt_back.sv
`default_nettype none

module jbt_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire jbt_pkg::bundle_t  pop_data,
  input  wire jbt_pkg::q_status_t status,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,
  output logic [4:0]             out_tuser,
  output logic                   out_tlast
);
  import jbt_pkg::*;

  bundle_t    cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic       at_last;
  logic       out_fire;
  result_t    sel;

  assign sel      = cur_r.res[idx_r];
  assign at_last  = (idx_r == cur_r.cnt - 2'd1);
  assign out_fire = cur_valid_r && out_tready;
  // Load the next bundle when empty or when the final result leaves
  assign pop      = !status.empty && (!cur_valid_r || (out_fire && at_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (out_fire) begin
      if (at_last) begin
        cur_valid_r <= 1'b0;
        idx_r       <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_data;
    end
  end

  assign out_tvalid = cur_valid_r;
  assign out_tdata  = {7'b0, sel.done, sel.data};
  assign out_tuser  = {sel.valid, sel.kind};
  assign out_tlast  = at_last;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.cnt != 2'd0 && idx_r < cur_r.cnt))
    else $error("result index outside held bundle");

endmodule

`default_nettype wire

### dv/json_byte_tokenizer_unit_test.sv
`timescale 1ns / 1ps

module json_byte_tokenizer_unit_test;
  import jbt_pkg::*;

  localparam int TEXT_BYTES     = 430;
  localparam int CALM_TAIL      = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam logic [4:0] NOT_HEX = 5'd16;

  // Scanner position between and inside tokens
  typedef enum logic [3:0] {
    SCAN_IDLE     = 4'd0,
    SCAN_WORD     = 4'd1,
    NUM_SIGN      = 4'd2,
    NUM_ZERO      = 4'd3,
    NUM_INT       = 4'd4,
    NUM_DOT       = 4'd5,
    NUM_FRAC      = 4'd6,
    NUM_EXP_MARK  = 4'd7,
    NUM_EXP_SIGN  = 4'd8,
    NUM_EXP       = 4'd9,
    STR_BODY      = 4'd10,
    STR_ESC       = 4'd11,
    STR_HEX       = 4'd12
  } scan_mode_t;

  // One token event as seen on the output stream
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data;
    logic       valid;
    logic       done;
    logic       last;
  } token_event_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  logic [7:0]   text_q[$];
  token_event_t expected_events[$];
  int src_gap      = 0;
  int sink_gap     = 0;
  int quiet_cycles = 0;
  int fail_count   = 0;

  // Tokenizer state mirrored by the predictor
  scan_mode_t  scan          = SCAN_IDLE;
  logic [1:0]  kw_which      = 2'd0;
  logic [2:0]  kw_pos        = 3'd0;
  logic [15:0] cp_accum      = 16'h0000;
  logic [2:0]  cp_digits     = 3'd0;
  logic        error_sticky  = 1'b0;

  string kw_word [3] = '{"null", "true", "false"};

  json_byte_tokenizer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------

  function automatic void push_event(input logic [3:0] kind, input logic [7:0] data,
                                     input logic valid, input logic done);
    token_event_t ev;
    ev.kind  = kind;
    ev.data  = valid ? data : 8'h00;
    ev.valid = valid;
    ev.done  = done;
    ev.last  = 1'b0;
    expected_events = {expected_events, ev};
  endfunction

  function automatic void raise_error();
    error_sticky = 1'b1;
    scan = SCAN_IDLE;
    push_event(K_ERROR, 8'h00, 1'b0, 1'b1);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    if (is_digit(b))
      return 5'(b - "0");
    if (b >= "a" && b <= "f")
      return 5'(b - "a" + 10);
    if (b >= "A" && b <= "F")
      return 5'(b - "A" + 10);
    return NOT_HEX;
  endfunction

  function automatic void begin_token(input logic [7:0] b);
    scan = SCAN_IDLE;
    case (b)
      8'h00: push_event(K_END, 8'h00, 1'b0, 1'b1);
      " ", 8'h09, 8'h0A, 8'h0D: ;
      "{": push_event(K_LBRACE, 8'h00, 1'b0, 1'b1);
      "}": push_event(K_RBRACE, 8'h00, 1'b0, 1'b1);
      "[": push_event(K_LBRACK, 8'h00, 1'b0, 1'b1);
      "]": push_event(K_RBRACK, 8'h00, 1'b0, 1'b1);
      ":": push_event(K_COLON, 8'h00, 1'b0, 1'b1);
      ",": push_event(K_COMMA, 8'h00, 1'b0, 1'b1);
      "n", "t", "f": begin
        kw_which = (b == "n") ? 2'd0 : (b == "t") ? 2'd1 : 2'd2;
        kw_pos = 3'd1;
        scan = SCAN_WORD;
      end
      "-": begin
        push_event(K_NUMBER, b, 1'b1, 1'b0);
        scan = NUM_SIGN;
      end
      "0": begin
        push_event(K_NUMBER, b, 1'b1, 1'b0);
        scan = NUM_ZERO;
      end
      "\"": scan = STR_BODY;
      default: begin
        if (is_digit(b)) begin
          push_event(K_NUMBER, b, 1'b1, 1'b0);
          scan = NUM_INT;
        end else begin
          raise_error();
        end
      end
    endcase
  endfunction

  // Close the number, then treat the byte as the next token's start
  function automatic void finish_number(input logic [7:0] b);
    push_event(K_NUMBER, 8'h00, 1'b0, 1'b1);
    begin_token(b);
  endfunction

  function automatic void emit_utf8(input logic [15:0] cp);
    if (cp <= 16'h007F) begin
      if (cp != 16'h0000)
        push_event(K_STRING, cp[7:0], 1'b1, 1'b0);
    end else if (cp <= 16'h07FF) begin
      push_event(K_STRING, 8'hC0 | {3'b000, cp[10:6]}, 1'b1, 1'b0);
      push_event(K_STRING, 8'h80 | {2'b00, cp[5:0]}, 1'b1, 1'b0);
    end else begin
      push_event(K_STRING, 8'hE0 | {4'b0000, cp[15:12]}, 1'b1, 1'b0);
      push_event(K_STRING, 8'h80 | {2'b00, cp[11:6]}, 1'b1, 1'b0);
      push_event(K_STRING, 8'h80 | {2'b00, cp[5:0]}, 1'b1, 1'b0);
    end
  endfunction

  function automatic void escape_char(input logic [7:0] b);
    scan = STR_BODY;
    case (b)
      "\"", "\\", "/": push_event(K_STRING, b, 1'b1, 1'b0);
      "b": push_event(K_STRING, 8'h08, 1'b1, 1'b0);
      "f": push_event(K_STRING, 8'h0C, 1'b1, 1'b0);
      "n": push_event(K_STRING, 8'h0A, 1'b1, 1'b0);
      "r": push_event(K_STRING, 8'h0D, 1'b1, 1'b0);
      "t": push_event(K_STRING, 8'h09, 1'b1, 1'b0);
      "u": begin
        cp_accum = 16'h0000;
        cp_digits = 3'd0;
        scan = STR_HEX;
      end
      default: raise_error();
    endcase
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b);
    int unsigned prior = expected_events.size();
    token_event_t tail;
    logic [4:0] nib;

    if (error_sticky) begin
      push_event(K_ERROR, 8'h00, 1'b0, 1'b1);
    end else begin
      case (scan)
        SCAN_WORD: begin
          if (b != kw_word[kw_which][kw_pos]) begin
            raise_error();
          end else begin
            kw_pos = kw_pos + 3'd1;
            if (kw_pos >= kw_word[kw_which].len()) begin
              push_event(K_NULL + {2'b00, kw_which}, 8'h00, 1'b0, 1'b1);
              scan = SCAN_IDLE;
            end
          end
        end
        NUM_SIGN: begin
          if (is_digit(b)) begin
            push_event(K_NUMBER, b, 1'b1, 1'b0);
            scan = (b == "0") ? NUM_ZERO : NUM_INT;
          end else begin
            raise_error();
          end
        end
        NUM_ZERO, NUM_INT: begin
          if (is_digit(b)) begin
            if (scan == NUM_ZERO)
              raise_error();
            else
              push_event(K_NUMBER, b, 1'b1, 1'b0);
          end else if (b == ".") begin
            push_event(K_NUMBER, b, 1'b1, 1'b0);
            scan = NUM_DOT;
          end else if (b == "e" || b == "E") begin
            push_event(K_NUMBER, b, 1'b1, 1'b0);
            scan = NUM_EXP_MARK;
          end else begin
            finish_number(b);
          end
        end
        NUM_DOT: begin
          if (is_digit(b)) begin
            push_event(K_NUMBER, b, 1'b1, 1'b0);
            scan = NUM_FRAC;
          end else begin
            raise_error();
          end
        end
        NUM_FRAC: begin
          if (is_digit(b)) begin
            push_event(K_NUMBER, b, 1'b1, 1'b0);
          end else if (b == "e" || b == "E") begin
            push_event(K_NUMBER, b, 1'b1, 1'b0);
            scan = NUM_EXP_MARK;
          end else begin
            finish_number(b);
          end
        end
        NUM_EXP_MARK: begin
          if (b == "+" || b == "-") begin
            push_event(K_NUMBER, b, 1'b1, 1'b0);
            scan = NUM_EXP_SIGN;
          end else if (is_digit(b)) begin
            push_event(K_NUMBER, b, 1'b1, 1'b0);
            scan = NUM_EXP;
          end else begin
            raise_error();
          end
        end
        NUM_EXP_SIGN: begin
          if (is_digit(b)) begin
            push_event(K_NUMBER, b, 1'b1, 1'b0);
            scan = NUM_EXP;
          end else begin
            raise_error();
          end
        end
        NUM_EXP: begin
          if (is_digit(b))
            push_event(K_NUMBER, b, 1'b1, 1'b0);
          else
            finish_number(b);
        end
        STR_BODY: begin
          if (b < 8'h20) begin
            raise_error();
          end else if (b == "\"") begin
            push_event(K_STRING, 8'h00, 1'b0, 1'b1);
            scan = SCAN_IDLE;
          end else if (b == "\\") begin
            scan = STR_ESC;
          end else begin
            push_event(K_STRING, b, 1'b1, 1'b0);
          end
        end
        STR_ESC: escape_char(b);
        STR_HEX: begin
          nib = hex_nibble(b);
          if (nib == NOT_HEX) begin
            raise_error();
          end else begin
            cp_accum = {cp_accum[11:0], nib[3:0]};
            cp_digits = cp_digits + 3'd1;
            if (cp_digits >= 3'd4) begin
              emit_utf8(cp_accum);
              cp_digits = 3'd0;
              scan = STR_BODY;
            end
          end
        end
        default: begin_token(b);
      endcase
    end

    // Flag the final event this byte produced
    if (expected_events.size() > prior) begin
      tail = expected_events[expected_events.size() - 1];
      tail.last = 1'b1;
      expected_events[expected_events.size() - 1] = tail;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------

  // Append one byte to the pending text
  function automatic void add_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      add_byte(s[i]);
  endtask

  task automatic push_digits(input int lo_count, input int hi_count);
    repeat ($urandom_range(lo_count, hi_count))
      add_byte(8'("0" + $urandom_range(0, 9)));
  endtask

  task automatic push_number();
    string enders;
    int pick;
    enders = " \t\n\r,:]}";
    if ($urandom_range(0, 2) == 0)
      add_byte("-");
    if ($urandom_range(0, 3) == 0) begin
      add_byte("0");
    end else begin
      add_byte(8'("0" + $urandom_range(1, 9)));
      push_digits(0, 3);
    end
    if ($urandom_range(0, 1) == 0) begin
      add_byte(".");
      push_digits(1, 3);
    end
    if ($urandom_range(0, 2) == 0) begin
      add_byte($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: add_byte("+");
        1: add_byte("-");
        default: ;
      endcase
      push_digits(1, 2);
    end
    // A number needs a byte that cannot continue it; byte 0 ends the text
    pick = $urandom_range(0, enders.len());
    add_byte(pick == enders.len() ? 8'h00 : enders[pick]);
  endtask

  task automatic push_unicode_escape();
    logic [15:0] cp;
    logic [3:0] nib;
    case ($urandom_range(0, 3))
      0: cp = 16'h0000;
      1: cp = 16'($urandom_range(16'h0001, 16'h007F));
      2: cp = 16'($urandom_range(16'h0080, 16'h07FF));
      default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
    endcase
    push_text("\\u");
    for (int i = 3; i >= 0; i--) begin
      nib = cp[i*4 +: 4];
      if (nib < 4'd10)
        add_byte(8'("0" + nib));
      else
        add_byte(8'(($urandom_range(0, 1) ? "a" : "A") + nib - 10));
    end
  endtask

  task automatic push_string();
    string escapes;
    logic [7:0] b;
    escapes = "\"\\/bfnrt";
    add_byte("\"");
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          b = 8'($urandom_range(8'h20, 8'hFF));
          // Step off the quote and the backslash
          if (b == "\"" || b == "\\")
            b = b + 8'd1;
          add_byte(b);
        end
        3: begin
          add_byte("\\");
          add_byte(escapes[$urandom_range(0, escapes.len() - 1)]);
        end
        default: push_unicode_escape();
      endcase
    end
    add_byte("\"");
  endtask

  // One malformed fragment; the error it raises holds until reset
  task automatic push_broken_fragment();
    case ($urandom_range(0, 10))
      0: push_text("-01");
      1: push_text("-x");
      2: push_text("1.x");
      3: push_text("1e]");
      4: push_text("2E+,");
      5: push_text("nullx");
      6: push_text("tru1");
      7: begin
        push_text("\"a");
        add_byte(8'($urandom_range(0, 31)));
      end
      8: push_text("\"\\q");
      9: push_text("\"\\u12g");
      default: push_text("@");
    endcase
  endtask

  task automatic build_text();
    string punct;
    string blanks;
    punct = "{}[]:,";
    blanks = " \t\n\r";

    // Directed opening: surrogate and zero code points, string byte extremes,
    // signed zero with fraction and signed exponent, upper-case exponent
    push_text("{\"\\uD800\\u0000");
    add_byte(8'h20);
    add_byte(8'h7F);
    add_byte(8'h80);
    add_byte(8'hFF);
    push_text("\":[-0.5e+3,1E9]}");
    add_byte(8'h00);

    // Well-formed token sequences with random content
    while (text_q.size() < TEXT_BYTES) begin
      repeat ($urandom_range(0, 1))
        add_byte(blanks[$urandom_range(0, 3)]);
      case ($urandom_range(0, 9))
        0, 1: add_byte(punct[$urandom_range(0, 5)]);
        2: push_text(kw_word[$urandom_range(0, 2)]);
        3, 4, 5: push_number();
        6, 7, 8: push_string();
        default: add_byte(8'h00);
      endcase
    end

    // Broken input last, then noise that must all read as errors
    push_broken_fragment();
    repeat (16)
      add_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------
  // Driver, response side, prediction and checking
  // ---------------------------------------------------------------------

  // Present text bytes; hold a byte until its transaction completes
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (src_gap > 0) begin
        src_gap--;
        in_tvalid <= 1'b0;
      end else if (text_q.size() > 0) begin
        in_tdata <= text_q.pop_front();
        in_tvalid <= 1'b1;
        if (text_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
          src_gap = $urandom_range(1, 8);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result stream in bursts, none near the end
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (text_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
        sink_gap = $urandom_range(1, 8);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      tokenize_byte(in_tdata);
  end

  function automatic void compare_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // Compare each result transaction with the oldest expected event
  always @(posedge clk) begin
    token_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d byte 0x%0h last %0b",
                 $time, out_tuser[3:0], out_tdata[7:0], out_tlast);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        compare_field("token_kind", 8'(want.kind), 8'(out_tuser[3:0]));
        compare_field("out_byte", want.data, out_tdata[7:0]);
        compare_field("byte_valid", 8'(want.valid), 8'(out_tuser[4]));
        compare_field("token_done", 8'(want.done), 8'(out_tdata[8]));
        compare_field("last_result", 8'(want.last), 8'(out_tlast));
      end
    end
  end

  // Abort when neither stream moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    build_text();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all bytes taken, all events seen, then a few quiet cycles
    while (text_q.size() != 0 || in_tvalid)
      @(posedge clk);
    while (expected_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
